>>> design/gtc_pkg.sv
// Package for the glyph template SSD classifier.
// Holds geometry, field widths, register codes, beat types and the base64 map.
// No dependencies.
`default_nettype none

package gtc_pkg;

  localparam int CELL_WIDTH  = 20;
  localparam int CELL_HEIGHT = 40;
  localparam int NUM_SYMBOLS = 65;

  localparam int CELL_PIXELS = CELL_WIDTH * CELL_HEIGHT;
  localparam int ADDR_W      = $clog2(CELL_PIXELS);

  localparam int SYM_W = 7;
  localparam int PIX_W = 10;
  localparam int VAL_W = 8;
  localparam int ERR_W = 26;
  localparam int POS_W = 10;
  localparam int SQ_W  = 2 * VAL_W;

  localparam logic [ERR_W-1:0] ERR_MAX       = {ERR_W{1'b1}};
  localparam logic [ERR_W-1:0] THRESH_RESET  = ERR_W'(32000);
  localparam logic [SYM_W-1:0] SYMBOLS_MAX   = SYM_W'(NUM_SYMBOLS);
  localparam logic [SYM_W-1:0] SYMBOLS_MIN   = SYM_W'(1);
  localparam logic [POS_W-1:0] COUNT_MAX     = {POS_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_LIMIT     = PIX_W'(CELL_PIXELS);
  // chain entry value, above any saturated sum
  localparam logic [ERR_W:0]   SCAN_INIT     = {1'b1, {ERR_W{1'b0}}};

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_SYMBOLS   = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_CELL = 1'b1
  } action_t;

  // one pixel beat as seen by every cell, registered in the cycle after acceptance
  typedef struct packed {
    logic             add;
    logic             clr;
    logic [VAL_W-1:0] val;
  } pix_ctl_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] idx;
    logic [ERR_W:0]   err;
  } scan_t;

  function automatic logic [6:0] b64_char(input logic [SYM_W-1:0] idx);
    logic [6:0] c;
    c = 7'd0;
    if (idx < SYM_W'(26))      c = 7'(7'd65 + 7'(idx));
    else if (idx < SYM_W'(52)) c = 7'(7'd97 + 7'(idx - SYM_W'(26)));
    else if (idx < SYM_W'(62)) c = 7'(7'd48 + 7'(idx - SYM_W'(52)));
    else if (idx == SYM_W'(62)) c = 7'd43;
    else if (idx == SYM_W'(63)) c = 7'd47;
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/gtc_cell.sv
// One classifier cell: template memory, SSD accumulator and a min-chain stage.
// Depends on gtc_pkg.
`default_nettype none

module gtc_cell import gtc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SYM_W-1:0] cell_id,
  input  wire logic [SYM_W-1:0] sym_count,
  input  wire logic             wr_en,
  input  wire logic [SYM_W-1:0] wr_slot,
  input  wire logic             rd_en,
  input  wire logic [PIX_W-1:0] addr,
  input  wire logic [VAL_W-1:0] wr_data,
  input  wire pix_ctl_t         pix,
  input  wire scan_t            scan_in,
  output scan_t                 scan_out
);

  logic [VAL_W-1:0] mem [CELL_PIXELS];
  logic [VAL_W-1:0] tpl;
  logic [ERR_W-1:0] acc;
  logic [VAL_W-1:0] diff;
  logic [SQ_W-1:0]  sq;
  logic [ERR_W:0]   sum;
  logic [ERR_W-1:0] acc_next;
  logic             active;
  logic             take;

  always_ff @(posedge clk) begin
    if (wr_en && wr_slot == cell_id) begin
      mem[addr[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      tpl <= mem[addr[ADDR_W-1:0]];
    end
  end

  assign active = cell_id < sym_count;
  assign diff   = (pix.val > tpl) ? pix.val - tpl : tpl - pix.val;
  assign sq     = diff * diff;
  assign sum    = {1'b0, acc} + (ERR_W+1)'(sq);

  always_comb begin
    acc_next = acc;
    if (pix.clr) begin
      acc_next = (pix.add && active) ? ERR_W'(sq) : '0;
    end else if (pix.add && active) begin
      acc_next = sum[ERR_W] ? ERR_MAX : sum[ERR_W-1:0];
    end
  end

  // the passing scan token reads and then clears this cell's sum
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (scan_in.valid) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign take = active && ({1'b0, acc} < scan_in.err);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    scan_out.idx <= take ? cell_id : scan_in.idx;
    scan_out.err <= take ? {1'b0, acc} : scan_in.err;
  end

endmodule

`default_nettype wire

>>> design/glyph_template_ssd_classifier.sv
// Top level of the glyph template SSD classifier: ports, frame control and cell row.
// Depends on gtc_pkg and gtc_cell.
//
//  channel | dir | beat carries
//  s_axis  | in  | template pixel load or cell pixel (tlast = cell_last)
//  m_axis  | out | best template, char, error, position, flags per cell
//  cfg     | in  | register write, always ready
//
// Load beats and cell pixels are taken one per cycle. After the last pixel of a
// cell, s_axis_tready stays low while the minimum runs down the chain of
// NUM_SYMBOLS cells, one cell per cycle, and longer while the previous
// result still waits in the m_axis output register.
// rst is synchronous; template memories are not cleared and must be loaded.
`default_nettype none

module glyph_template_ssd_classifier import gtc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [6:0] symbol_slot, [16:7] pixel_index, [24:17] pixel_value, rest zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] action, [1] frame_start
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [6:0] symbol_index, [13:7] symbol_char, [39:14] cell_error,
  // [49:40] cell_position, [50] new_max, [51] over_threshold, rest zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [ERR_W-1:0]      cfg_data
);

  logic [SYM_W-1:0] in_slot;
  logic [PIX_W-1:0] in_pix;
  logic [VAL_W-1:0] in_val;
  logic             in_fstart;
  logic             in_acc;
  logic             is_cell;
  logic             in_range;
  logic             take;

  logic [ERR_W-1:0] thresh;
  logic [SYM_W-1:0] sym_cfg;
  logic [SYM_W-1:0] sym_clamp;
  logic [SYM_W-1:0] sym_count;

  logic             busy;
  logic             pending;
  logic             s1_last;
  pix_ctl_t         pix;

  logic [ERR_W-1:0] frame_max;
  logic [POS_W-1:0] cell_cnt;
  logic             stopped;

  scan_t            chain [NUM_SYMBOLS+1];
  scan_t            scan_end;
  logic [ERR_W-1:0] best_err;
  logic             raised;
  logic [ERR_W-1:0] max_next;
  logic             over;
  logic             start;

  logic             out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign in_slot   = s_axis_tdata[SYM_W-1:0];
  assign in_pix    = s_axis_tdata[SYM_W+PIX_W-1:SYM_W];
  assign in_val    = s_axis_tdata[SYM_W+PIX_W+VAL_W-1:SYM_W+PIX_W];
  assign in_fstart = s_axis_tuser[1];

  assign s_axis_tready = !busy;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_cell  = action_t'(s_axis_tuser[0]) == ACT_CELL;
  assign in_range = in_pix < PIX_LIMIT;
  assign take     = in_acc && is_cell && !(stopped && !in_fstart);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh  <= THRESH_RESET;
      sym_cfg <= SYMBOLS_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: thresh  <= cfg_data;
        REG_SYMBOLS:   sym_cfg <= cfg_data[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sym_clamp = sym_cfg;
    if (sym_cfg < SYMBOLS_MIN)      sym_clamp = SYMBOLS_MIN;
    else if (sym_cfg > SYMBOLS_MAX) sym_clamp = SYMBOLS_MAX;
  end

  // pixel stage: template read happens at accept, accumulate in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      pix.add   <= 1'b0;
      pix.clr   <= 1'b0;
      s1_last   <= 1'b0;
      sym_count <= SYMBOLS_MAX;
    end else begin
      pix.add <= take && in_range;
      pix.clr <= take && in_fstart;
      s1_last <= take && s_axis_tlast;
      if (in_acc) begin
        sym_count <= sym_clamp;
      end
    end
    pix.val <= in_val;
  end

  assign start    = pending && !out_valid;
  assign chain[0] = '{valid: start, idx: '0, err: SCAN_INIT};

  for (genvar g = 0; g < NUM_SYMBOLS; g++) begin : g_cell
    gtc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_id   (SYM_W'(g)),
      .sym_count (sym_count),
      .wr_en     (in_acc && !is_cell && in_range),
      .wr_slot   (in_slot),
      .rd_en     (in_acc && is_cell && in_range),
      .addr      (in_pix),
      .wr_data   (in_val),
      .pix       (pix),
      .scan_in   (chain[g]),
      .scan_out  (chain[g+1])
    );
  end

  assign scan_end = chain[NUM_SYMBOLS];
  assign best_err = scan_end.err[ERR_W-1:0];
  assign raised   = best_err > frame_max;
  assign max_next = raised ? best_err : frame_max;
  assign over     = max_next > thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= 1'b0;
      frame_max <= '0;
      cell_cnt  <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && s_axis_tlast) begin
        busy <= 1'b1;
      end else if (scan_end.valid) begin
        busy <= 1'b0;
      end

      if (s1_last) begin
        pending <= 1'b1;
      end else if (start) begin
        pending <= 1'b0;
      end

      if (take && in_fstart) begin
        frame_max <= '0;
        cell_cnt  <= '0;
        stopped   <= 1'b0;
      end else if (scan_end.valid) begin
        frame_max <= max_next;
        if (cell_cnt != COUNT_MAX) begin
          cell_cnt <= cell_cnt + POS_W'(1);
        end
        if (over) begin
          stopped <= 1'b1;
        end
      end

      if (scan_end.valid) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_end.valid) begin
      out_data <= {4'b0, over, raised, cell_cnt, best_err,
                   b64_char(scan_end.idx), scan_end.idx};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

>>> design/gtc_checker.sv
// Port-level checker for the glyph template SSD classifier, bound to the top level.
// Depends on gtc_pkg.
`default_nettype none

module gtc_checker import gtc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[6:0] <= SYMBOLS_MAX - SYM_W'(1))
    else $error("symbol index beyond template count");

  a_char_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6:0] == 7'd64 |-> m_axis_tdata[13:7] == 7'd0)
    else $error("last template index must map to zero char");

  a_new_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[39:14] != '0)
    else $error("frame maximum raised by a zero error");

endmodule

bind glyph_template_ssd_classifier gtc_checker u_gtc_checker (.*);

`default_nettype wire

>>> tb/tb_glyph_template_ssd_classifier.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_template_ssd_classifier: loads templates, walks a directed
// table of pixel beats and register writes, then random frames, checked by a nearest-template
// predictor kept in step with the block. Depends on gtc_pkg and the design files only.

module tb_glyph_template_ssd_classifier;
  import gtc_pkg::*;

  localparam int SETTLE_CYCLES = NUM_SYMBOLS + 15;
  localparam int POOL_SIZE = 16;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RUN_LIMIT_NS = 25_000_000;
  localparam logic [ERR_W-1:0] THRESH_TOP = ERR_W'(52020000);

  typedef struct packed {
    action_t          act;
    logic [SYM_W-1:0] slot;
    logic [PIX_W-1:0] pix;
    logic [VAL_W-1:0] val;
    logic             fs;
    logic             last;
  } pixel_beat_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic             over;
    logic             new_max;
    logic [POS_W-1:0] pos;
    logic [ERR_W-1:0] err;
    logic [6:0]       chr;
    logic [SYM_W-1:0] idx;
  } glyph_result_t;

  typedef struct {
    bit               is_cfg;
    cfg_reg_t         rsel;
    logic [ERR_W-1:0] cdata;
    pixel_beat_t      beat;
    int               reps;
    bit               typed;
    glyph_result_t    want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [ERR_W-1:0]      cfg_data = '0;

  // predictor state
  logic [VAL_W-1:0] glyph_mem [NUM_SYMBOLS][CELL_PIXELS];
  logic [ERR_W-1:0] ssd_acc [NUM_SYMBOLS];
  logic [ERR_W-1:0] frame_peak;
  logic [ERR_W-1:0] thresh_q;
  logic [POS_W-1:0] cell_no;
  logic [SYM_W-1:0] sym_q;
  bit               frame_halted;
  string            b64_map = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  glyph_result_t pending_q[$];
  script_row_t   script_q[$];
  int            pool_pix[POOL_SIZE];
  int            fail_cnt = 0;
  bit            burst_mode = 1'b0;
  bit            rx_hold_req = 1'b0;

  glyph_template_ssd_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int live_symbols();
    if (sym_q < 1) return 1;
    if (sym_q > NUM_SYMBOLS) return NUM_SYMBOLS;
    return int'(sym_q);
  endfunction

  // Advances the predictor by one accepted beat; returns 1 when a result is due.
  function automatic bit classify(input pixel_beat_t b, output glyph_result_t r);
    int               n;
    int               best;
    logic [ERR_W-1:0] best_err;
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] d;
    logic [SQ_W-1:0]  sq;
    logic [ERR_W:0]   sum;
    bit               raised;
    r = '0;
    if (b.act == ACT_LOAD) begin
      if (b.slot < NUM_SYMBOLS && b.pix < CELL_PIXELS) glyph_mem[b.slot][b.pix] = b.val;
      return 1'b0;
    end
    if (b.fs) begin
      frame_peak = '0;
      cell_no = '0;
      frame_halted = 1'b0;
      foreach (ssd_acc[s]) ssd_acc[s] = '0;
    end
    if (frame_halted) return 1'b0;
    n = live_symbols();
    if (b.pix < CELL_PIXELS) begin
      for (int s = 0; s < n; s++) begin
        t = glyph_mem[s][b.pix];
        d = (b.val > t) ? b.val - t : t - b.val;
        sq = d * d;
        sum = ssd_acc[s] + sq;
        ssd_acc[s] = (sum > ERR_MAX) ? ERR_MAX : sum[ERR_W-1:0];
      end
    end
    if (!b.last) return 1'b0;
    best = 0;
    best_err = ssd_acc[0];
    for (int s = 1; s < n; s++) begin
      if (ssd_acc[s] < best_err) begin
        best_err = ssd_acc[s];
        best = s;
      end
    end
    raised = best_err > frame_peak;
    if (raised) frame_peak = best_err;
    r.over = frame_peak > thresh_q;
    if (r.over) frame_halted = 1'b1;
    r.idx = SYM_W'(best);
    r.chr = (best < 64) ? 7'(b64_map[best]) : 7'd0;
    r.err = best_err;
    r.pos = cell_no;
    r.new_max = raised;
    if (cell_no != COUNT_MAX) cell_no = cell_no + 1'b1;
    foreach (ssd_acc[s]) ssd_acc[s] = '0;
    return 1'b1;
  endfunction

  function automatic int pick_pix();
    if ($urandom_range(0, 9) == 0) return $urandom_range(CELL_PIXELS, 1023);
    return pool_pix[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic script_row_t beat_row(action_t act, int slot, int pix, int val, bit fs,
                                           bit last, int reps);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.rsel = REG_THRESHOLD;
    row.cdata = '0;
    row.beat.act = act;
    row.beat.slot = SYM_W'(slot);
    row.beat.pix = PIX_W'(pix);
    row.beat.val = VAL_W'(val);
    row.beat.fs = fs;
    row.beat.last = last;
    row.reps = reps;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic script_row_t cfg_row(cfg_reg_t rsel, logic [ERR_W-1:0] data);
    script_row_t row;
    row = beat_row(ACT_LOAD, 0, 0, 0, 1'b0, 1'b0, 0);
    row.is_cfg = 1'b1;
    row.rsel = rsel;
    row.cdata = data;
    return row;
  endfunction

  function automatic script_row_t typed_row(script_row_t row, int idx, byte chr, int err, int pos,
                                            bit nm, bit over);
    row.typed = 1'b1;
    row.want = '0;
    row.want.idx = SYM_W'(idx);
    row.want.chr = chr[6:0];
    row.want.err = ERR_W'(err);
    row.want.pos = POS_W'(pos);
    row.want.new_max = nm;
    row.want.over = over;
    return row;
  endfunction

  function automatic void add_row(script_row_t row);
    script_q.insert(script_q.size(), row);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic send_beat(input pixel_beat_t b, input bit typed, input glyph_result_t want);
    int            gap;
    glyph_result_t r;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'({b.val, b.pix, b.slot});
    s_axis_tuser <= {b.fs, b.act};
    s_axis_tlast <= b.last;
    do @(posedge clk); while (!s_axis_tready);
    if (classify(b, r)) pending_q.insert(pending_q.size(), typed ? want : r);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // stop sending, wait for every pending result, then let the chain settle
  task automatic drain_results();
    sender_idle();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t rsel, input logic [ERR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= rsel;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (rsel == REG_THRESHOLD) thresh_q = data;
    else sym_q = data[SYM_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result sink: random stalls, one long hold on request
  initial begin : rx
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = RX_HOLD_CYCLES;
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 16);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : mon
    glyph_result_t got;
    glyph_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = glyph_result_t'(m_axis_tdata);
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: symbol_index %0d cell_error %0d", got.idx, got.err);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        check_field("symbol_index", want.idx, got.idx);
        check_field("symbol_char", want.chr, got.chr);
        check_field("cell_error", want.err, got.err);
        check_field("cell_position", want.pos, got.pos);
        check_field("new_max", want.new_max, got.new_max);
        check_field("over_threshold", want.over, got.over);
      end
    end
  end

  initial begin : stim
    pixel_beat_t      b;
    glyph_result_t    no_result;
    int               n_sent;
    int               len;
    int               target;
    int               spread;
    int               v;
    int               r;
    logic [ERR_W-1:0] thr;
    logic [ERR_W-1:0] sym_data;

    no_result = '0;
    thresh_q = THRESH_RESET;
    sym_q = SYMBOLS_MAX;
    frame_peak = '0;
    cell_no = '0;
    frame_halted = 1'b0;
    foreach (ssd_acc[s]) ssd_acc[s] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pixel positions that cells read; every template gets loaded at each of them
    for (int i = 0; i < 12; i++) pool_pix[i] = (i == 0) ? 0 : (i == 11) ? 799 : (1 << (i - 1));
    for (int i = 12; i < POOL_SIZE; i++) pool_pix[i] = $urandom_range(3, 798);

    // position 0 holds 3*slot, position 799 holds 255 everywhere (all-way tie)
    foreach (pool_pix[i]) begin
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        b.act = ACT_LOAD;
        b.slot = SYM_W'(s);
        b.pix = PIX_W'(pool_pix[i]);
        b.val = (pool_pix[i] == 0) ? VAL_W'(3 * s) : (pool_pix[i] == 799) ? 8'd255 :
                VAL_W'($urandom);
        b.fs = 1'($urandom);
        b.last = 1'($urandom);
        send_beat(b, 1'b0, no_result);
      end
    end

    add_row(typed_row(beat_row(ACT_CELL, 0, 900, 0, 1, 1, 1), 0, "A", 0, 0, 0, 0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 0, 0, 1, 1), 0, "A", 0, 1, 0, 0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 255, 0, 1, 1), 64, 0, 3969, 2, 1, 0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 189, 0, 1, 1), 63, "/", 0, 3, 0, 0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 186, 0, 1, 1), 62, "+", 0, 4, 0, 0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 156, 0, 1, 1), 52, "0", 0, 5, 0, 0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 78, 0, 1, 1), 26, "a", 0, 6, 0, 0));
    add_row(beat_row(ACT_CELL, 0, 0, 2, 0, 1, 1));
    // four tied full-scale pixels push the frame over the reset threshold
    add_row(beat_row(ACT_CELL, 0, 799, 0, 0, 0, 3));
    add_row(beat_row(ACT_CELL, 0, 799, 0, 0, 1, 1));
    add_row(beat_row(ACT_CELL, 0, 0, 0, 0, 1, 1));
    add_row(beat_row(ACT_LOAD, 100, 0, 7, 1, 1, 1));
    add_row(beat_row(ACT_LOAD, 127, 1023, 255, 0, 0, 1));
    add_row(beat_row(ACT_LOAD, 5, 850, 9, 0, 1, 1));
    add_row(cfg_row(REG_THRESHOLD, '0));
    add_row(cfg_row(REG_SYMBOLS, '0));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 255, 1, 1, 1), 0, "A", 65025, 0, 1, 1));
    add_row(cfg_row(REG_THRESHOLD, THRESH_TOP));
    add_row(cfg_row(REG_SYMBOLS, ERR_W'(127)));
    // accumulator saturation
    add_row(beat_row(ACT_CELL, 0, 799, 0, 1, 0, 1032));
    add_row(typed_row(beat_row(ACT_CELL, 0, 799, 0, 0, 1, 1), 0, "A", int'(ERR_MAX),
                      0, 1, 1));
    // cell position saturation
    add_row(beat_row(ACT_CELL, 0, 1000, 255, 1, 1, 1030));
    // frame start in the middle of a cell
    add_row(beat_row(ACT_CELL, 0, 0, 100, 0, 0, 1));
    add_row(typed_row(beat_row(ACT_CELL, 0, 0, 3, 1, 1, 1), 1, "B", 0, 0, 0, 0));

    foreach (script_q[i]) begin
      if (script_q[i].is_cfg) begin
        drain_results();
        write_reg(script_q[i].rsel, script_q[i].cdata);
      end else begin
        for (int k = 0; k < script_q[i].reps; k++) begin
          b = script_q[i].beat;
          if (k > 0) b.fs = 1'b0;
          send_beat(b, script_q[i].typed, script_q[i].want);
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain_results();
      burst_mode = (p == 1);
      case (p)
        0: thr = ERR_W'($urandom_range(0, 3000));
        1: thr = THRESH_TOP;
        2: thr = ERR_W'($urandom_range(0, 52020000));
        3: thr = '0;
        4: thr = ERR_W'($urandom_range(500, 20000));
        default: thr = ERR_W'($urandom_range(0, 6000));
      endcase
      case (p)
        0: sym_data = ERR_W'(NUM_SYMBOLS);
        1: sym_data = ERR_W'($urandom_range(1, NUM_SYMBOLS));
        2: sym_data = ERR_W'(1);
        3: sym_data = ERR_W'($urandom_range(2, NUM_SYMBOLS)) | (ERR_W'($urandom) << SYM_W);
        4: sym_data = ERR_W'(127);
        default: sym_data = ERR_W'($urandom_range(0, 127));
      endcase
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_SYMBOLS, sym_data);
      if (p == 2) rx_hold_req = 1'b1;

      n_sent = 0;
      while (n_sent < 70) begin
        r = $urandom_range(0, 99);
        b.slot = SYM_W'($urandom);
        b.val = VAL_W'($urandom);
        b.fs = 1'($urandom);
        b.last = 1'($urandom);
        if (r < 6) begin
          b.act = ACT_LOAD;
          b.pix = PIX_W'($urandom);
          send_beat(b, 1'b0, no_result);
          n_sent++;
        end else if (r < 14) begin
          b.act = ACT_LOAD;
          b.slot = SYM_W'($urandom_range(0, NUM_SYMBOLS - 1));
          b.pix = PIX_W'(pool_pix[$urandom_range(0, POOL_SIZE - 1)]);
          send_beat(b, 1'b0, no_result);
          n_sent++;
        end else if (r < 20) begin
          b.act = ACT_CELL;
          b.pix = PIX_W'(pick_pix());
          send_beat(b, 1'b0, no_result);
          n_sent++;
        end else begin
          // well-formed cell aimed close to one template
          len = $urandom_range(1, 6);
          target = $urandom_range(0, live_symbols() - 1);
          spread = $urandom_range(0, 24);
          for (int j = 0; j < len; j++) begin
            b.act = ACT_CELL;
            b.slot = SYM_W'($urandom);
            b.pix = PIX_W'(pick_pix());
            if (b.pix < CELL_PIXELS) begin
              v = int'(glyph_mem[target][b.pix]) + $urandom_range(0, 2 * spread) - spread;
              v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            end else begin
              v = $urandom_range(0, 255);
            end
            b.val = VAL_W'(v);
            b.fs = (j == 0) && ($urandom_range(0, 3) == 0);
            b.last = (j == len - 1);
            send_beat(b, 1'b0, no_result);
          end
          n_sent += len;
        end
      end
    end
    burst_mode = 1'b0;

    drain_results();
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
